// File: sv/dtb_pkg.sv
`timescale 1ns / 1ps
// dtb_pkg: shared codes, widths and the stage control type for the texture blend
// no dependencies; compile first

package dtb_pkg;

    // request modes
    localparam logic [2:0] MODE_TEX_WR  = 3'd0;
    localparam logic [2:0] MODE_MAP_WR  = 3'd1;
    localparam logic [2:0] MODE_SINE_WR = 3'd2;
    localparam logic [2:0] MODE_FRAME   = 3'd3;
    localparam logic [2:0] MODE_DRAW    = 3'd4;

    // field widths
    localparam int MODE_W = 3;
    localparam int ADDR_W = 16;
    localparam int WORD_W = 16;
    localparam int SINE_W = 16;
    localparam int FC_W   = 10;
    localparam int PIX_W  = 8;

    // stores
    localparam int TEX_DEPTH     = 65536;
    localparam int SINE_DEPTH    = 256;
    localparam int SINE_AW       = 8;
    localparam int DEF_MAP_DEPTH = 65536;

    // phase step between the two sine lookups of one axis
    localparam logic [SINE_AW-1:0] PHASE_STEP = 8'd16;

    typedef struct packed {
        logic             valid;
        logic [MODE_W-1:0] mode;
    } t_ctl;

    function automatic logic f_hit(input t_ctl c, input logic [MODE_W-1:0] code);
        return c.valid && (c.mode == code);
    endfunction

endpackage

// File: sv/displacement_texture_blend.sv
`timescale 1ns / 1ps
// displacement_texture_blend: top level, stage registers and output buffering
// depends on dtb_pkg, dtb_ram, dtb_offset and dtb_texel
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_stall   i_mode i_address i_word_data i_sine_value
//                                            i_frame_count
//  result    out        o_valid / i_stall   o_pixel_value o_pixel_index
//
// one request per cycle while o_stall is low; both texels of a draw come from the two
// texture read ports at once; a draw result reaches the output register via the stages
// for map and sine read, texel address, texel read and average
// reset clears the stage valids, the output/skid valids and both offsets; stores keep contents
// a stalled result moves into a one-entry skid register; while the skid is full
// every stage and memory port holds, and o_stall is that registered full flag.

module displacement_texture_blend #(
    parameter int MAP_DEPTH = dtb_pkg::DEF_MAP_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [dtb_pkg::MODE_W-1:0]         i_mode,
    input  logic [dtb_pkg::ADDR_W-1:0]         i_address,
    input  logic [dtb_pkg::WORD_W-1:0]         i_word_data,
    input  logic signed [dtb_pkg::SINE_W-1:0]  i_sine_value,
    input  logic [dtb_pkg::FC_W-1:0]           i_frame_count,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [dtb_pkg::PIX_W-1:0]          o_pixel_value,
    output logic [dtb_pkg::ADDR_W-1:0]         o_pixel_index
);
    import dtb_pkg::*;

    // pipeline advance: everything moves unless the skid holds a result
    logic w_adv;

    // stage registers, valid bits travel with the payload
    t_ctl              r_s1_ctl, r_s2_ctl, r_s3_ctl;
    logic [ADDR_W-1:0] r_s1_addr, r_s2_addr, r_s3_addr, r_s4_addr;
    logic [WORD_W-1:0] r_s1_word, r_s2_word;
    logic [PIX_W-1:0]  r_s3_byte;
    logic [SINE_W-1:0] r_s1_sine, r_s2_sine;
    logic [FC_W-1:0]   r_s1_fc, r_s2_fc;
    logic              r_s4_valid;

    // output register and skid entry
    logic              r_out_valid, r_skid_valid;
    logic [PIX_W-1:0]  r_out_value, r_skid_value;
    logic [ADDR_W-1:0] r_out_index, r_skid_index;
    logic              n_out_valid, n_skid_valid;

    logic [ADDR_W-1:0] w_off_a, w_off_b;
    logic [PIX_W-1:0]  w_pixel;
    logic              w_produce, w_out_taken;

    assign w_adv   = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // control part of the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl   <= '0;
            r_s2_ctl   <= '0;
            r_s3_ctl   <= '0;
            r_s4_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_ctl   <= '{valid: i_valid, mode: i_mode};
            r_s2_ctl   <= r_s1_ctl;
            r_s3_ctl   <= r_s2_ctl;
            r_s4_valid <= f_hit(r_s3_ctl, MODE_DRAW);
        end
    end

    // payload part of the stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_addr <= i_address;
            r_s1_word <= i_word_data;
            r_s1_sine <= i_sine_value;
            r_s1_fc   <= i_frame_count;
            r_s2_addr <= r_s1_addr;
            r_s2_word <= r_s1_word;
            r_s2_sine <= r_s1_sine;
            r_s2_fc   <= r_s1_fc;
            r_s3_addr <= r_s2_addr;
            r_s3_byte <= r_s2_word[PIX_W-1:0];
            r_s4_addr <= r_s3_addr;
        end
    end

    // per-frame offsets from the sine stores
    dtb_offset u_offset (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_s1_ctl  (r_s1_ctl),
        .i_s1_addr (r_s1_addr[SINE_AW-1:0]),
        .i_s1_sine (r_s1_sine),
        .i_s1_fc   (r_s1_fc),
        .i_s2_ctl  (r_s2_ctl),
        .i_s2_addr (r_s2_addr[SINE_AW-1:0]),
        .i_s2_sine (r_s2_sine),
        .i_s2_fc   (r_s2_fc),
        .i_s3_ctl  (r_s3_ctl),
        .o_off_a   (w_off_a),
        .o_off_b   (w_off_b)
    );

    // displacement lookup, texel fetch and average
    dtb_texel #(.MAP_DEPTH(MAP_DEPTH)) u_texel (
        .i_clk         (i_clk),
        .i_adv         (w_adv),
        .i_s1_ctl      (r_s1_ctl),
        .i_s1_addr     (r_s1_addr),
        .i_s1_word     (r_s1_word),
        .i_s2_addr     (r_s2_addr),
        .i_s3_ctl      (r_s3_ctl),
        .i_s3_addr     (r_s3_addr),
        .i_s3_byte     (r_s3_byte),
        .i_off_a       (w_off_a),
        .i_off_b       (w_off_b),
        .o_pixel_value (w_pixel)
    );

    // a draw leaving stage four produces a result
    assign w_produce   = w_adv && r_s4_valid;
    assign w_out_taken = r_out_valid && !i_stall;

    // output register and skid occupancy
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            // skid drains into a free output register
            if (w_out_taken || !r_out_valid) begin
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (w_produce) begin
            if (r_out_valid && !w_out_taken) begin
                n_skid_valid = 1'b1;
            end else begin
                n_out_valid = 1'b1;
            end
        end else if (w_out_taken) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_taken || !r_out_valid) begin
                r_out_value <= r_skid_value;
                r_out_index <= r_skid_index;
            end
        end else if (w_produce) begin
            if (r_out_valid && !w_out_taken) begin
                r_skid_value <= w_pixel;
                r_skid_index <= r_s4_addr;
            end else begin
                r_out_value <= w_pixel;
                r_out_index <= r_s4_addr;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_value = r_out_value;
    assign o_pixel_index = r_out_index;

endmodule

// File: sv/dtb_ram.sv
`timescale 1ns / 1ps
// dtb_ram: generic one-write, two-read memory with registered read data
// no dependencies

module dtb_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// File: sv/dtb_offset.sv
`timescale 1ns / 1ps
// dtb_offset: sine stores and the per-frame texture offset pipeline
// depends on dtb_pkg and dtb_ram

module dtb_offset (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  dtb_pkg::t_ctl                 i_s1_ctl,
    input  logic [dtb_pkg::SINE_AW-1:0]   i_s1_addr,
    input  logic [dtb_pkg::SINE_W-1:0]    i_s1_sine,
    input  logic [dtb_pkg::FC_W-1:0]      i_s1_fc,
    input  dtb_pkg::t_ctl                 i_s2_ctl,
    input  logic [dtb_pkg::SINE_AW-1:0]   i_s2_addr,
    input  logic [dtb_pkg::SINE_W-1:0]    i_s2_sine,
    input  logic [dtb_pkg::FC_W-1:0]      i_s2_fc,
    input  dtb_pkg::t_ctl                 i_s3_ctl,
    output logic [dtb_pkg::ADDR_W-1:0]    o_off_a,
    output logic [dtb_pkg::ADDR_W-1:0]    o_off_b
);
    import dtb_pkg::*;

    logic [SINE_AW-1:0] w_wob_idx, w_pu, w_pu_step, w_pv, w_pv_step;
    logic [SINE_W-1:0]  w_a_wob, w_a_pu, w_c_pu_step, w_b_pv, w_b_pv_step;
    logic               w_we_s1, w_we_s2;
    logic signed [SINE_W-1:0] w_wob, w_u1, w_u2, w_v1, w_v2;
    logic [7:0]         r_u1, r_u2;
    logic [ADDR_W-1:0]  w_off_a, w_off_b;
    logic [ADDR_W-1:0]  r_off_a, r_off_b;

    // stage 1: wobble index and horizontal phase
    assign w_wob_idx = i_s1_fc[FC_W-1:2];
    assign w_pu      = i_s1_fc[SINE_AW-1:0] + i_s1_fc[SINE_AW:1];
    assign w_pu_step = w_pu + PHASE_STEP;
    assign w_we_s1   = i_adv && f_hit(i_s1_ctl, MODE_SINE_WR);

    // copy read at stage 1: wobble and first horizontal lookup
    dtb_ram #(.WIDTH(SINE_W), .DEPTH(SINE_DEPTH)) u_sine_a (
        .i_clk     (i_clk),
        .i_we      (w_we_s1),
        .i_waddr   (i_s1_addr),
        .i_wdata   (i_s1_sine),
        .i_re      (i_adv),
        .i_raddr_a (w_wob_idx),
        .i_raddr_b (w_pu),
        .o_rdata_a (w_a_wob),
        .o_rdata_b (w_a_pu)
    );

    // copy read at stage 1: second horizontal lookup
    dtb_ram #(.WIDTH(SINE_W), .DEPTH(SINE_DEPTH)) u_sine_c (
        .i_clk     (i_clk),
        .i_we      (w_we_s1),
        .i_waddr   (i_s1_addr),
        .i_wdata   (i_s1_sine),
        .i_re      (i_adv),
        .i_raddr_a (w_pu_step),
        .i_raddr_b (w_pu_step),
        .o_rdata_a (w_c_pu_step),
        .o_rdata_b ()
    );

    // stage 2: vertical phase bent by the wobble
    assign w_wob     = $signed(w_a_wob) >>> 10;
    assign w_pv      = i_s2_fc[SINE_AW-1:0] + w_wob[SINE_AW-1:0];
    assign w_pv_step = w_pv + PHASE_STEP;
    assign w_we_s2   = i_adv && f_hit(i_s2_ctl, MODE_SINE_WR);
    assign w_u1      = $signed(w_a_pu) >>> 8;
    assign w_u2      = $signed(w_c_pu_step) >>> 8;

    // copy read at stage 2: both vertical lookups
    dtb_ram #(.WIDTH(SINE_W), .DEPTH(SINE_DEPTH)) u_sine_b (
        .i_clk     (i_clk),
        .i_we      (w_we_s2),
        .i_waddr   (i_s2_addr),
        .i_wdata   (i_s2_sine),
        .i_re      (i_adv),
        .i_raddr_a (w_pv),
        .i_raddr_b (w_pv_step),
        .o_rdata_a (w_b_pv),
        .o_rdata_b (w_b_pv_step)
    );

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_u1 <= w_u1[7:0];
            r_u2 <= w_u2[7:0];
        end
    end

    // stage 3: offset = v * 256 + u, wrapping at 16 bits
    assign w_v1    = $signed(w_b_pv) >>> 8;
    assign w_v2    = $signed(w_b_pv_step) >>> 8;
    assign w_off_a = {w_v1[7:0], 8'h00} + {{8{r_u1[7]}}, r_u1};
    assign w_off_b = {w_v2[7:0], 8'h00} + {{8{r_u2[7]}}, r_u2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_a <= '0;
            r_off_b <= '0;
        end else if (i_adv && f_hit(i_s3_ctl, MODE_FRAME)) begin
            r_off_a <= w_off_a;
            r_off_b <= w_off_b;
        end
    end

    assign o_off_a = r_off_a;
    assign o_off_b = r_off_b;

endmodule

// File: sv/dtb_texel.sv
`timescale 1ns / 1ps
// dtb_texel: displacement map, texture store and the two-tap average
// depends on dtb_pkg and dtb_ram

module dtb_texel #(
    parameter int MAP_DEPTH = dtb_pkg::DEF_MAP_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_adv,
    input  dtb_pkg::t_ctl                i_s1_ctl,
    input  logic [dtb_pkg::ADDR_W-1:0]   i_s1_addr,
    input  logic [dtb_pkg::WORD_W-1:0]   i_s1_word,
    input  logic [dtb_pkg::ADDR_W-1:0]   i_s2_addr,
    input  dtb_pkg::t_ctl                i_s3_ctl,
    input  logic [dtb_pkg::ADDR_W-1:0]   i_s3_addr,
    input  logic [dtb_pkg::PIX_W-1:0]    i_s3_byte,
    input  logic [dtb_pkg::ADDR_W-1:0]   i_off_a,
    input  logic [dtb_pkg::ADDR_W-1:0]   i_off_b,
    output logic [dtb_pkg::PIX_W-1:0]    o_pixel_value
);
    import dtb_pkg::*;

    localparam int MAP_AW = $clog2(MAP_DEPTH);

    logic              w_s1_in_map, w_s2_in_map, w_map_we, w_tex_we;
    logic [WORD_W-1:0] w_map_q;
    logic [WORD_W-1:0] r_disp;
    logic [ADDR_W-1:0] w_tex_a, w_tex_b;
    logic [PIX_W-1:0]  w_tex_qa, w_tex_qb;
    logic [PIX_W:0]    w_sum;

    // stage 1: map write and read share the port timing
    assign w_s1_in_map = {1'b0, i_s1_addr} < (ADDR_W+1)'(MAP_DEPTH);
    assign w_map_we    = i_adv && f_hit(i_s1_ctl, MODE_MAP_WR) && w_s1_in_map;

    dtb_ram #(.WIDTH(WORD_W), .DEPTH(MAP_DEPTH)) u_map (
        .i_clk     (i_clk),
        .i_we      (w_map_we),
        .i_waddr   (i_s1_addr[MAP_AW-1:0]),
        .i_wdata   (i_s1_word),
        .i_re      (i_adv),
        .i_raddr_a (i_s1_addr[MAP_AW-1:0]),
        .i_raddr_b (i_s1_addr[MAP_AW-1:0]),
        .o_rdata_a (w_map_q),
        .o_rdata_b ()
    );

    // stage 2: pixels beyond the map take a zero displacement
    assign w_s2_in_map = {1'b0, i_s2_addr} < (ADDR_W+1)'(MAP_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_disp <= w_s2_in_map ? w_map_q : '0;
        end
    end

    // stage 3: two texel addresses, texture write on the same port timing
    assign w_tex_a  = r_disp + i_off_a;
    assign w_tex_b  = r_disp + i_off_b;
    assign w_tex_we = i_adv && f_hit(i_s3_ctl, MODE_TEX_WR);

    dtb_ram #(.WIDTH(PIX_W), .DEPTH(TEX_DEPTH)) u_texture (
        .i_clk     (i_clk),
        .i_we      (w_tex_we),
        .i_waddr   (i_s3_addr),
        .i_wdata   (i_s3_byte),
        .i_re      (i_adv),
        .i_raddr_a (w_tex_a),
        .i_raddr_b (w_tex_b),
        .o_rdata_a (w_tex_qa),
        .o_rdata_b (w_tex_qb)
    );

    // stage 4: average of the two texels
    assign w_sum         = {1'b0, w_tex_qa} + {1'b0, w_tex_qb};
    assign o_pixel_value = w_sum[PIX_W:1];

endmodule
